// ===== hw/rtl/sna_pkg.sv =====
// Shared types and constants for the sequence number allocator.
// Holds table geometry, field widths, status codes, controller states and the
// command/status structs between controller and datapath. Depends on nothing.
package sna_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam int ADDR_W   = 8;
    localparam int NETFN_W  = 6;
    localparam int CMD_W    = 8;
    localparam int TICK_W   = 32;
    localparam int SEQ_W    = 8;
    localparam int STATUS_W = 2;

    localparam int KEY_W   = ADDR_W + NETFN_W + CMD_W;
    localparam int TAG_W   = KEY_W + SEQ_W;
    localparam int ENTRY_W = TAG_W + TICK_W;

    // Sequence number space; numbers 0 and SEQ_SPACE-1 are never handed out.
    localparam int SEQ_SPACE   = 1 << SEQ_W;
    localparam int PICK_W      = 32;
    localparam int POS_W       = $clog2(PICK_W);
    localparam int PICK_CHUNKS = SEQ_SPACE / PICK_W;
    localparam int CHUNK_W     = $clog2(PICK_CHUNKS);

    localparam int SCAN_CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CNT_W      = (SCAN_CNT_W > CHUNK_W) ? SCAN_CNT_W : CHUNK_W;

    localparam logic [TICK_W-1:0] WINDOW_RESET = TICK_W'(6000);

    // Reserved numbers start out marked as used.
    localparam logic [SEQ_SPACE-1:0] USED_INIT = {1'b1, {(SEQ_SPACE-2){1'b0}}, 1'b1};

    typedef enum logic [STATUS_W-1:0] {
        ST_ASSIGNED  = 2'd0,
        ST_RESPONSE  = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic               load;
        logic               rd;
        logic [SLOT_W-1:0]  rd_addr;
        logic               eval;
        logic               pick;
        logic [CHUNK_W-1:0] chunk;
        logic               finish;
    } t_dp_cmd;

    typedef struct packed {
        logic pick_hit;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== hw/rtl/sna_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Width and depth are parameters; depends on nothing.
module sna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic                                         i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/sna_ctrl.sv =====
// Controller of the sequence number allocator: accept, table scan,
// number pick and result hand-off. Depends on sna_pkg.
module sna_ctrl import sna_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_is_resp,
    output logic    o_stall,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        o_stall       = 1'b1;
        o_cmd         = '0;
        o_cmd.rd_addr = r_cnt[SLOT_W-1:0];
        o_cmd.chunk   = r_cnt[CHUNK_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = i_is_resp ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                // read slot r_cnt, judge slot r_cnt-1
                o_cmd.rd   = (r_cnt != CNT_W'(TABLE_DEPTH));
                o_cmd.eval = (r_cnt != '0);
                if (r_cnt == CNT_W'(TABLE_DEPTH)) begin
                    n_cnt   = '0;
                    n_state = S_PICK;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                if (i_sts.pick_hit ||
                    r_cnt[CHUNK_W-1:0] == CHUNK_W'(PICK_CHUNKS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/sna_datapath.sv =====
// Datapath of the sequence number allocator: item registers, slot valid bits,
// slot table RAM, used-number mask, pick logic and result register.
// Depends on sna_pkg and sna_ram.
module sna_datapath import sna_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [TICK_W-1:0]   i_cfg_wdata,
    input  logic [ADDR_W-1:0]   i_responder_addr,
    input  logic [NETFN_W-1:0]  i_net_function,
    input  logic [CMD_W-1:0]    i_command_code,
    input  logic [TICK_W-1:0]   i_now_tick,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [SEQ_W-1:0]    o_assigned_seq
);

    function automatic logic [POS_W-1:0] lowest_zero(input logic [PICK_W-1:0] bits);
        logic [POS_W-1:0] pos;
        pos = '0;
        for (int i = PICK_W - 1; i >= 0; i--) begin
            if (!bits[i]) begin
                pos = POS_W'(i);
            end
        end
        return pos;
    endfunction

    logic [ADDR_W-1:0]    r_addr;
    logic [NETFN_W-1:0]   r_netfn;
    logic [CMD_W-1:0]     r_cmd;
    logic [TICK_W-1:0]    r_now;
    logic [TICK_W-1:0]    r_window;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [SEQ_SPACE-1:0] r_used;
    logic                 r_free_found;
    logic [SLOT_W-1:0]    r_free_idx;
    logic                 r_pick_found;
    logic [SEQ_W-1:0]     r_pick;
    logic [SLOT_W-1:0]    r_eval_idx;
    logic                 r_out_valid;
    t_status              r_out_status;
    logic [SEQ_W-1:0]     r_out_seq;

    logic [KEY_W-1:0]   key;
    logic [ENTRY_W-1:0] rd_data;
    logic [TAG_W-1:0]   ent_tag;
    logic [TICK_W-1:0]  ent_stamp;
    logic [SEQ_W-1:0]   ent_seq;
    logic [TICK_W-1:0]  age;
    logic               stale;
    logic               live;
    logic               match;
    logic [PICK_W-1:0]  chunk_bits;
    logic               pick_hit;
    t_status            res_status;
    logic               commit;
    logic               out_free;

    assign key = {r_addr, r_netfn, r_cmd};

    sna_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (commit),
        .i_waddr (r_free_idx),
        .i_wdata ({key, r_pick, r_now}),
        .i_re    (i_cmd.rd),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (rd_data)
    );

    // slot judgement on the entry read in the previous cycle
    assign ent_tag   = rd_data[ENTRY_W-1 -: TAG_W];
    assign ent_stamp = rd_data[TICK_W-1:0];
    assign ent_seq   = ent_tag[SEQ_W-1:0];
    assign age       = r_now - ent_stamp;
    assign stale     = r_valid[r_eval_idx] && (age > r_window);
    assign live      = r_valid[r_eval_idx] && !stale;
    assign match     = live && (ent_tag[TAG_W-1 -: KEY_W] == key);

    assign chunk_bits = r_used[{i_cmd.chunk, POS_W'(0)} +: PICK_W];
    assign pick_hit   = !(&chunk_bits);

    always_comb begin
        priority if (r_netfn[0]) begin
            res_status = ST_RESPONSE;
        end else if (!r_pick_found) begin
            res_status = ST_EXHAUSTED;
        end else if (!r_free_found) begin
            res_status = ST_FULL;
        end else begin
            res_status = ST_ASSIGNED;
        end
    end

    assign commit   = i_cmd.finish && (res_status == ST_ASSIGNED);
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr  <= i_responder_addr;
            r_netfn <= i_net_function;
            r_cmd   <= i_command_code;
            r_now   <= i_now_tick;
        end
        if (i_cmd.rd) begin
            r_eval_idx <= i_cmd.rd_addr;
        end
        if (i_cmd.load) begin
            r_used <= USED_INIT;
        end else if (i_cmd.eval && match) begin
            r_used[ent_seq] <= 1'b1;
        end
        if (i_cmd.eval && !live && !r_free_found) begin
            r_free_idx <= r_eval_idx;
        end
        if (i_cmd.pick && pick_hit && !r_pick_found) begin
            r_pick <= {i_cmd.chunk, lowest_zero(chunk_bits)};
        end
        if (i_cmd.finish) begin
            r_out_status <= res_status;
            r_out_seq    <= (res_status == ST_ASSIGNED) ? r_pick : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window     <= WINDOW_RESET;
            r_valid      <= '0;
            r_free_found <= 1'b0;
            r_pick_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            if (i_cmd.eval && stale) begin
                r_valid[r_eval_idx] <= 1'b0;
            end
            if (commit) begin
                r_valid[r_free_idx] <= 1'b1;
            end
            if (i_cmd.load) begin
                r_free_found <= 1'b0;
                r_pick_found <= 1'b0;
            end else begin
                if (i_cmd.eval && !live) begin
                    r_free_found <= 1'b1;
                end
                if (i_cmd.pick && pick_hit) begin
                    r_pick_found <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.pick_hit = pick_hit;
    assign o_sts.out_free = out_free;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_assigned_seq = r_out_seq;

endmodule

// ===== hw/rtl/sequence_number_allocator.sv =====
// Sequence number allocator with expiry: top level joining controller and datapath.
// Depends on sna_pkg, sna_ctrl, sna_datapath (and sna_ram below it).
//
// Each item is one outgoing message header. A response (odd net function)
// returns status RESPONSE with sequence 0 and leaves the table untouched; its
// result is registered from the done state once the result register is free,
// and the block then returns to idle for the next item. A request sweeps the
// slot table once, reading one slot per cycle from the table RAM: slots whose
// modular age now_tick - stamp exceeds the reuse window are dropped, live
// slots with the same address, function and command mark their number as
// used, and the lowest free slot is noted. The used-number mask is then
// searched 32 numbers per cycle for the lowest free number in 1..254, and the
// number is written with the tick sampled at accept into the free slot. After
// the sweep and the search the result is registered once the result register
// is free, and the block then returns to idle for the next item; the lowest
// free number usually lies in the first group of 32. Status EXHAUSTED or FULL
// returns sequence 0; expiry done during that sweep stays. Slot valid bits
// are flip-flops cleared by reset, so the block is ready right after reset.
// One item is in work at a time; the result register lets a finished result
// wait for the consumer while the next item is accepted, and an item that
// finishes while the previous result still waits holds until it is taken.
// reuse_window is written through i_cfg_we/i_cfg_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce.
module sequence_number_allocator import sna_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [TICK_W-1:0]   i_cfg_wdata,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [ADDR_W-1:0]   i_responder_addr,
    input  logic [NETFN_W-1:0]  i_net_function,
    input  logic [CMD_W-1:0]    i_command_code,
    input  logic [TICK_W-1:0]   i_now_tick,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [SEQ_W-1:0]    o_assigned_seq
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequencer: accept, sweep, pick, hand off
    sna_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_is_resp (i_net_function[0]),
        .o_stall   (o_stall),
        .o_cmd     (dp_cmd),
        .i_sts     (dp_sts)
    );

    // table, masks and result register
    sna_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_responder_addr (i_responder_addr),
        .i_net_function   (i_net_function),
        .i_command_code   (i_command_code),
        .i_now_tick       (i_now_tick),
        .i_cmd            (dp_cmd),
        .o_sts            (dp_sts),
        .i_out_stall      (i_stall),
        .o_out_valid      (o_valid),
        .o_status         (o_status),
        .o_assigned_seq   (o_assigned_seq)
    );

endmodule

// ===== hw/rtl/sna_checker.sv =====
// Port-level checks for the sequence number allocator, bound to the top level.
// Depends on sna_pkg.
module sna_checker import sna_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic [STATUS_W-1:0] o_status,
    input logic [SEQ_W-1:0]    o_assigned_seq
);

    // a held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_assigned_seq))
        else $error("result changed while stalled");

    // only an assignment carries a number
    a_seq_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_ASSIGNED) |-> (o_assigned_seq == '0))
        else $error("nonzero sequence without assignment");

    // assigned numbers stay within 1..254
    a_seq_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_ASSIGNED) |->
            (o_assigned_seq != '0) && (o_assigned_seq != '1))
        else $error("assigned sequence out of range");

    // an accepted item makes the block stall its input, so no two items are accepted back to back
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second item accepted back to back");

endmodule

bind sequence_number_allocator sna_checker u_sna_checker (.*);
